>>> hdl/afws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afws_pkg
// Shared types, widths and constants for the front wheel speed pipeline.
// ----------------------------------------------------------------------------
package afws_pkg;

    // field widths
    localparam int SPD_W = 16;
    localparam int CRD_W = 17;
    localparam int CFG_W = 8;
    localparam int OUT_W = 24;
    localparam int IDX_W = 2;

    // datapath widths
    localparam int DIF_W = 19;              // offsets from a wheel, signed
    localparam int ABS_W = 17;              // magnitude of an offset
    localparam int U2_W  = 31;              // speed squared
    localparam int SQ_W  = 34;              // sum of two squares
    localparam int HALF_W = SQ_W / 2;
    localparam int PP_W  = U2_W + HALF_W;   // partial product
    localparam int NUM_W = U2_W + SQ_W + 16 - 1; // scaled dividend, below 2^80
    localparam int QW    = 47;              // quotient bits kept
    localparam int DR_W  = SQ_W + QW;       // divider remainder
    localparam int RT_W  = 24;              // root bits
    localparam int SR_W  = 2 * RT_W + 1;    // root remainder

    // per-wheel unit latency: overflow check, divide steps, root steps
    localparam int SUB_LAT  = 1 + QW + RT_W;
    // input beat to result strobe
    localparam int PIPE_LAT = 5 + SUB_LAT + 1;

    localparam logic [OUT_W-1:0] SPD_POS_MAX = 24'h7FFFFF;
    localparam logic [OUT_W-1:0] SPD_NEG_MAX = 24'h800000;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 8'd31;
    localparam logic [CFG_W-1:0] LENGTH_RST = 8'd48;

    // register indexes
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_LENGTH = 2'd1;

    typedef enum logic [1:0] {
        MODE_STRAIGHT,
        MODE_ZERO,
        MODE_RZERO,
        MODE_CALC
    } mode_t;

    // control that travels alongside each beat
    typedef struct packed {
        mode_t                    mode;
        logic                     neg;
        logic signed [SPD_W-1:0]  spd;
    } side_t;

    // square of a signed offset whose magnitude fits ABS_W bits
    function automatic logic [SQ_W-1:0] sq_off(input logic signed [DIF_W-1:0] a);
        logic signed [DIF_W-1:0] n;
        logic [ABS_W-1:0]        m;
        n = -a;
        m = a[DIF_W-1] ? n[ABS_W-1:0] : a[ABS_W-1:0];
        return SQ_W'(m) * SQ_W'(m);
    endfunction

endpackage

>>> hdl/ackermann_front_wheel_speeds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ackermann_front_wheel_speeds
// Front wheel speeds for a turning centre: speed scaled by the ratio of
// wheel-to-centre and origin-to-centre distances, with straight-line,
// zero-speed and zero-radius cases and 24-bit saturation.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; busy is never raised.
// The depth is set by the 47 divide steps and 24 root steps, one per stage.
// Reset clears the valid bits and loads width 31 and length 48.
// Results are strobed for one cycle; the receiver cannot stall.
module ackermann_front_wheel_speeds (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [afws_pkg::SPD_W-1:0] drive_speed,
    input  logic signed [afws_pkg::CRD_W-1:0] centre_x,
    input  logic signed [afws_pkg::CRD_W-1:0] centre_y,
    input  logic                              cfg_we,
    input  logic [afws_pkg::IDX_W-1:0]        cfg_index,
    input  logic [afws_pkg::CFG_W-1:0]        cfg_data,
    output logic                              done,
    output logic signed [afws_pkg::OUT_W-1:0] left_speed,
    output logic signed [afws_pkg::OUT_W-1:0] right_speed,
    output logic                              radius_zero,
    output logic                              saturated
);
    import afws_pkg::*;

    logic [CFG_W-1:0] wb_width_reg, wb_length_reg;

    // stage 1: offsets and case decode
    logic                    p1_valid_reg;
    side_t                   p1_side_reg, p1_side_next;
    logic [SPD_W-1:0]        p1_u_reg, p1_u_next;
    logic signed [DIF_W-1:0] p1_x_reg, p1_y_reg, p1_dxl_reg, p1_dxr_reg, p1_dy_reg;
    logic signed [DIF_W-1:0] hw, hl;
    logic [ABS_W-1:0]        ay;
    logic [ABS_W-1:0]        thr;
    logic signed [SPD_W-1:0] neg_spd;
    logic signed [CRD_W-1:0] neg_y;

    // stage 2: squares
    logic             p2_valid_reg;
    side_t            p2_side_reg;
    logic [U2_W-1:0]  p2_u2_reg;
    logic [SQ_W-1:0]  p2_x2_reg, p2_y2_reg, p2_dxl2_reg, p2_dxr2_reg, p2_dy2_reg;

    // stage 3: sums of squares
    logic             p3_valid_reg;
    side_t            p3_side_reg;
    logic [U2_W-1:0]  p3_u2_reg;
    logic [SQ_W-1:0]  p3_b_reg, p3_al_reg, p3_ar_reg;

    // stage 4: partial products
    logic             p4_valid_reg;
    side_t            p4_side_reg;
    logic [SQ_W-1:0]  p4_b_reg;
    logic [PP_W-1:0]  p4_ll_reg, p4_lh_reg, p4_rl_reg, p4_rh_reg;

    // stage 5: scaled dividends
    logic             p5_valid_reg;
    side_t            p5_side_reg;
    logic [SQ_W-1:0]  p5_b_reg;
    logic [NUM_W-1:0] p5_nl_reg, p5_nr_reg;

    // side line alongside the root units
    logic             dl_valid_reg [0:SUB_LAT-1];
    side_t            dl_side_reg  [0:SUB_LAT-1];

    logic [RT_W-1:0]  root_l, root_r;
    logic             ovf_l, ovf_r;

    // output stage
    side_t            o_side;
    logic [OUT_W-1:0] lim, mag_l, mag_r;
    logic             clip_l, clip_r;
    logic [OUT_W-1:0] left_next, right_next;
    logic             rz_next, sat_next;
    logic             done_reg;
    logic [OUT_W-1:0] left_reg, right_reg;
    logic             rz_reg, sat_reg;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_width_reg  <= WIDTH_RST;
            wb_length_reg <= LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  wb_width_reg  <= cfg_data;
                REG_LENGTH: wb_length_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // stage 1 decode
    always_comb
    begin
        hw      = $signed({{(DIF_W-CFG_W-3){1'b0}}, wb_width_reg, 3'b000});
        hl      = $signed({{(DIF_W-CFG_W-3){1'b0}}, wb_length_reg, 3'b000});
        neg_spd = -drive_speed;
        neg_y   = -centre_y;
        ay      = centre_y[CRD_W-1] ? neg_y : centre_y;
        thr     = ABS_W'({wb_length_reg[CFG_W-1:1], 4'b0000});
        p1_u_next = drive_speed[SPD_W-1] ? neg_spd : drive_speed;
        p1_side_next.neg = drive_speed[SPD_W-1];
        p1_side_next.spd = drive_speed;
        priority if (centre_x == '0 && ay > thr)
            p1_side_next.mode = MODE_STRAIGHT;
        else if (drive_speed == '0)
            p1_side_next.mode = MODE_ZERO;
        else if (centre_x == '0 && centre_y == '0)
            p1_side_next.mode = MODE_RZERO;
        else
            p1_side_next.mode = MODE_CALC;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            for (int i = 0; i < SUB_LAT; i++)
                dl_valid_reg[i] <= 1'b0;
            done_reg <= 1'b0;
            rz_reg   <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= start && !busy;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            dl_valid_reg[0] <= p5_valid_reg;
            for (int i = 1; i < SUB_LAT; i++)
                dl_valid_reg[i] <= dl_valid_reg[i-1];
            done_reg <= dl_valid_reg[SUB_LAT-1];
            if (dl_valid_reg[SUB_LAT-1])
            begin
                rz_reg  <= rz_next;
                sat_reg <= sat_next;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        p1_side_reg <= p1_side_next;
        p1_u_reg    <= p1_u_next;
        p1_x_reg    <= DIF_W'(centre_x);
        p1_y_reg    <= DIF_W'(centre_y);
        p1_dxl_reg  <= DIF_W'(centre_x) - hw;
        p1_dxr_reg  <= DIF_W'(centre_x) + hw;
        p1_dy_reg   <= DIF_W'(centre_y) - hl;

        p2_side_reg <= p1_side_reg;
        p2_u2_reg   <= U2_W'(p1_u_reg) * U2_W'(p1_u_reg);
        p2_x2_reg   <= sq_off(p1_x_reg);
        p2_y2_reg   <= sq_off(p1_y_reg);
        p2_dxl2_reg <= sq_off(p1_dxl_reg);
        p2_dxr2_reg <= sq_off(p1_dxr_reg);
        p2_dy2_reg  <= sq_off(p1_dy_reg);

        p3_side_reg <= p2_side_reg;
        p3_u2_reg   <= p2_u2_reg;
        p3_b_reg    <= p2_x2_reg + p2_y2_reg;
        p3_al_reg   <= p2_dxl2_reg + p2_dy2_reg;
        p3_ar_reg   <= p2_dxr2_reg + p2_dy2_reg;

        p4_side_reg <= p3_side_reg;
        p4_b_reg    <= p3_b_reg;
        p4_ll_reg   <= PP_W'(p3_u2_reg) * PP_W'(p3_al_reg[HALF_W-1:0]);
        p4_lh_reg   <= PP_W'(p3_u2_reg) * PP_W'(p3_al_reg[SQ_W-1:HALF_W]);
        p4_rl_reg   <= PP_W'(p3_u2_reg) * PP_W'(p3_ar_reg[HALF_W-1:0]);
        p4_rh_reg   <= PP_W'(p3_u2_reg) * PP_W'(p3_ar_reg[SQ_W-1:HALF_W]);

        p5_side_reg <= p4_side_reg;
        p5_b_reg    <= p4_b_reg;
        p5_nl_reg   <= (NUM_W'(p4_ll_reg) + (NUM_W'(p4_lh_reg) << HALF_W)) << 16;
        p5_nr_reg   <= (NUM_W'(p4_rl_reg) + (NUM_W'(p4_rh_reg) << HALF_W)) << 16;

        dl_side_reg[0] <= p5_side_reg;
        for (int i = 1; i < SUB_LAT; i++)
            dl_side_reg[i] <= dl_side_reg[i-1];

        left_reg  <= left_next;
        right_reg <= right_next;
    end

    // divide and root, one unit per wheel
    afws_wheel_root u_root_l (
        .clk  (clk),
        .num  (p5_nl_reg),
        .den  (p5_b_reg),
        .root (root_l),
        .ovf  (ovf_l)
    );

    afws_wheel_root u_root_r (
        .clk  (clk),
        .num  (p5_nr_reg),
        .den  (p5_b_reg),
        .root (root_r),
        .ovf  (ovf_r)
    );

    // clip, sign and case select
    always_comb
    begin
        o_side = dl_side_reg[SUB_LAT-1];
        lim    = o_side.neg ? SPD_NEG_MAX : SPD_POS_MAX;
        clip_l = ovf_l || (root_l > lim);
        clip_r = ovf_r || (root_r > lim);
        mag_l  = clip_l ? lim : root_l;
        mag_r  = clip_r ? lim : root_r;
        unique case (o_side.mode)
            MODE_STRAIGHT:
            begin
                left_next  = {o_side.spd, 8'h00};
                right_next = {o_side.spd, 8'h00};
                rz_next    = 1'b0;
                sat_next   = 1'b0;
            end
            MODE_ZERO:
            begin
                left_next  = '0;
                right_next = '0;
                rz_next    = 1'b0;
                sat_next   = 1'b0;
            end
            MODE_RZERO:
            begin
                left_next  = o_side.neg ? SPD_NEG_MAX : SPD_POS_MAX;
                right_next = o_side.neg ? SPD_NEG_MAX : SPD_POS_MAX;
                rz_next    = 1'b1;
                sat_next   = 1'b1;
            end
            MODE_CALC:
            begin
                left_next  = o_side.neg ? -mag_l : mag_l;
                right_next = o_side.neg ? -mag_r : mag_r;
                rz_next    = 1'b0;
                sat_next   = clip_l || clip_r;
            end
            default:
            begin
                left_next  = '0;
                right_next = '0;
                rz_next    = 1'b0;
                sat_next   = 1'b0;
            end
        endcase
    end

    assign done        = done_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign radius_zero = rz_reg;
    assign saturated   = sat_reg;

    // every accepted beat comes out a fixed time later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##PIPE_LAT done)
        else $error("result strobe missing after accepted beat");

    // a zero radius always reports saturation
    a_rz_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && radius_zero |-> saturated)
        else $error("radius_zero without saturated");

    // a zero radius gives the same full scale speed on both wheels
    a_rz_equal: assert property (@(posedge clk) disable iff (!rst_n)
        done && radius_zero |-> left_speed == right_speed)
        else $error("radius_zero with unequal wheel speeds");

    // saturation means some wheel sits at a limit
    a_sat_lim: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> left_speed == SPD_POS_MAX || left_speed == SPD_NEG_MAX
                              || right_speed == SPD_POS_MAX || right_speed == SPD_NEG_MAX)
        else $error("saturated with no wheel at a limit");

endmodule

>>> hdl/afws_wheel_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afws_wheel_root
// Pipelined floor(sqrt(floor(num / den))): one overflow check stage, one
// restoring divide step per stage, then one root digit per stage.
// ----------------------------------------------------------------------------
module afws_wheel_root (
    input  logic                       clk,
    input  logic [afws_pkg::NUM_W-1:0] num,
    input  logic [afws_pkg::SQ_W-1:0]  den,
    output logic [afws_pkg::RT_W-1:0]  root,
    output logic                       ovf
);
    import afws_pkg::*;

    logic [DR_W-1:0] rem_reg [0:QW];
    logic [QW-1:0]   q_reg   [0:QW];
    logic [SQ_W-1:0] den_reg [0:QW];
    logic            ovf_reg [0:QW];

    logic [SR_W-1:0] sq_rem_reg  [1:RT_W];
    logic [RT_W-1:0] sq_root_reg [1:RT_W];
    logic            sq_ovf_reg  [1:RT_W];

    // quotient would not fit the kept bits: the root is past full scale
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= DR_W'(num);
        q_reg[0]   <= '0;
        den_reg[0] <= den;
        ovf_reg[0] <= DR_W'(num) >= (DR_W'(den) << QW);
    end

    // restoring divide, most significant quotient bit first
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int BIT = QW - 1 - k;
        logic [DR_W-1:0] dsh;
        logic            take;
        assign dsh  = DR_W'(den_reg[k]) << BIT;
        assign take = rem_reg[k] >= dsh;
        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= take ? rem_reg[k] - dsh : rem_reg[k];
            q_reg[k+1]   <= q_reg[k] | (QW'(take) << BIT);
            den_reg[k+1] <= den_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    // digit by digit square root of the quotient
    for (genvar j = 0; j < RT_W; j++) begin : g_sqrt
        localparam int BIT = RT_W - 1 - j;
        logic [SR_W-1:0] rem_in;
        logic [RT_W-1:0] root_in;
        logic            ovf_in;
        logic [SR_W-1:0] trial;
        logic            take;
        if (j == 0) begin : g_first
            assign rem_in  = SR_W'(q_reg[QW]);
            assign root_in = '0;
            assign ovf_in  = ovf_reg[QW];
        end else begin : g_next
            assign rem_in  = sq_rem_reg[j];
            assign root_in = sq_root_reg[j];
            assign ovf_in  = sq_ovf_reg[j];
        end
        assign trial = (SR_W'(root_in) << (BIT + 1)) | (SR_W'(1) << (2 * BIT));
        assign take  = rem_in >= trial;
        always_ff @(posedge clk)
        begin
            sq_rem_reg[j+1]  <= take ? rem_in - trial : rem_in;
            sq_root_reg[j+1] <= root_in | (RT_W'(take) << BIT);
            sq_ovf_reg[j+1]  <= ovf_in;
        end
    end

    assign root = sq_root_reg[RT_W];
    assign ovf  = sq_ovf_reg[RT_W];

endmodule

>>> bench/tb_ackermann_front_wheel_speeds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ackermann_front_wheel_speeds
// Drives speed and turning-centre beats through the front wheel speed block
// under several track and wheelbase settings and with random sender gaps.
// Every result strobe is checked field by field against an in-bench model
// of the exact integer wheel speed rule, or against typed values for the
// easy rows of the directed table.
// ----------------------------------------------------------------------------
module tb_ackermann_front_wheel_speeds;
    import afws_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE = 2'd2;
    localparam int RAND_PER_SET = 150;
    localparam int N_SETS = 7;
    localparam int N_DIR = 16;

    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
        logic                    rz;
        logic                    sat;
    } speeds_t;

    typedef struct packed {
        logic signed [SPD_W-1:0] spd;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic                    typed;
        speeds_t                 want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [SPD_W-1:0] drive_speed = '0;
    logic signed [CRD_W-1:0] centre_x = '0;
    logic signed [CRD_W-1:0] centre_y = '0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic done;
    logic signed [OUT_W-1:0] left_speed;
    logic signed [OUT_W-1:0] right_speed;
    logic radius_zero;
    logic saturated;

    logic [CFG_W-1:0] track_w = WIDTH_RST;
    logic [CFG_W-1:0] base_l = LENGTH_RST;
    speeds_t pending_speeds[$];
    int errors = 0;
    int gap_pct = 0;

    ackermann_front_wheel_speeds u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .drive_speed(drive_speed), .centre_x(centre_x), .centre_y(centre_y),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .left_speed(left_speed), .right_speed(right_speed),
        .radius_zero(radius_zero), .saturated(saturated)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // integer square root, floor
    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] sq_mag(input longint v);
        longint m;
        m = v < 0 ? -v : v;
        return 64'(m) * 64'(m);
    endfunction

    // one wheel: s*256*sqrt(a/b), clipped to the 24-bit range
    function automatic logic [OUT_W-1:0] wheel(input int s, input logic [63:0] a,
                                               input logic [63:0] b, inout logic sat);
        logic [127:0] num;
        logic [127:0] q;
        logic [63:0] u;
        logic [63:0] m;
        logic [63:0] lim;
        lim = s < 0 ? 64'd8388608 : 64'd8388607;
        u = s < 0 ? 64'(-s) : 64'(s);
        num = (128'(u * u) * 128'(a)) << 16;
        if (num >= (128'(b) << 64))
        begin
            m = lim;
            sat = 1'b1;
        end
        else
        begin
            q = num / 128'(b);
            m = isqrt(q[63:0]);
            if (m > lim)
            begin
                m = lim;
                sat = 1'b1;
            end
        end
        return s < 0 ? OUT_W'(-m) : OUT_W'(m);
    endfunction

    function automatic speeds_t front_speeds(input logic signed [SPD_W-1:0] spd,
                                             input logic signed [CRD_W-1:0] cx,
                                             input logic signed [CRD_W-1:0] cy);
        speeds_t r;
        int s;
        longint x;
        longint y;
        longint hw;
        longint dy;
        logic [63:0] b;
        s = spd;
        x = cx;
        y = cy;
        r = '0;
        if (x == 0 && (y < 0 ? -y : y) > 16 * longint'(base_l >> 1))
        begin
            r.left = OUT_W'(s * 256);
            r.right = r.left;
        end
        else if (s == 0)
            r = '0;
        else if (x == 0 && y == 0)
        begin
            r.rz = 1'b1;
            r.sat = 1'b1;
            r.left = s > 0 ? SPD_POS_MAX : SPD_NEG_MAX;
            r.right = r.left;
        end
        else
        begin
            hw = 8 * longint'(track_w);
            dy = y - 8 * longint'(base_l);
            b = sq_mag(x) + sq_mag(y);
            r.left = wheel(s, sq_mag(x - hw) + sq_mag(dy), b, r.sat);
            r.right = wheel(s, sq_mag(x + hw) + sq_mag(dy), b, r.sat);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result check at every strobe
    always @(posedge clk)
    begin
        speeds_t w;
        if (rst_n && done)
        begin
            if (pending_speeds.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                w = pending_speeds.pop_front();
                if (left_speed !== w.left) report_mismatch("left_speed", left_speed, w.left);
                if (right_speed !== w.right)
                    report_mismatch("right_speed", right_speed, w.right);
                if (radius_zero !== w.rz) report_mismatch("radius_zero", radius_zero, w.rz);
                if (saturated !== w.sat) report_mismatch("saturated", saturated, w.sat);
            end
        end
    end

    // one input beat; start stays high across back-to-back beats
    task automatic send_beat(input logic signed [SPD_W-1:0] s, input logic signed [CRD_W-1:0] x,
                             input logic signed [CRD_W-1:0] y, input logic typed,
                             input speeds_t want);
        // each cycle idles with the given chance
        while ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        drive_speed = s;
        centre_x = x;
        centre_y = y;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        pending_speeds.push_back(typed ? want : front_speeds(s, x, y));
        @(negedge clk);
    endtask

    // wait for every result, then let the pipe settle
    task automatic drain();
        start = 1'b0;
        while (pending_speeds.size() != 0) @(negedge clk);
        repeat (PIPE_LAT + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_WIDTH) track_w = v;
        else if (idx == REG_LENGTH) base_l = v;
    endtask

    task automatic random_beat();
        logic signed [SPD_W-1:0] s;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        int k;
        int edge_y;
        k = $urandom_range(99);
        s = SPD_W'($urandom);
        x = CRD_W'($urandom);
        y = CRD_W'($urandom);
        edge_y = 16 * (base_l >> 1) + $urandom_range(0, 2) - 1;
        if (k < 20)
        begin
            // around the straight-line threshold
            x = '0;
            y = $urandom_range(1) ? CRD_W'(edge_y) : CRD_W'(-edge_y);
        end
        else if (k < 25)
            s = '0;
        else if (k < 30)
        begin
            x = '0;
            y = '0;
        end
        else if (k < 60)
        begin
            // centre near the car
            x = CRD_W'(int'($urandom_range(0, 8000)) - 4000);
            y = CRD_W'(int'($urandom_range(0, 8000)) - 4000);
        end
        send_beat(s, x, y, 1'b0, '0);
    endtask

    initial
    begin
        row_t dir_rows[N_DIR];
        logic [CFG_W-1:0] set_w[N_SETS];
        logic [CFG_W-1:0] set_l[N_SETS];
        dir_rows = '{
            '{16'sd100, 17'sd0, 17'sd10000, 1'b1, '{24'sd25600, 24'sd25600, 1'b0, 1'b0}},
            '{16'sd32767, 17'sd0, 17'sd385, 1'b1, '{24'sd8388352, 24'sd8388352, 1'b0, 1'b0}},
            '{-16'sd32768, 17'sd0, -17'sd65536, 1'b1,
              '{-24'sd8388608, -24'sd8388608, 1'b0, 1'b0}},
            '{16'sd0, 17'sd500, 17'sd700, 1'b1, '{24'sd0, 24'sd0, 1'b0, 1'b0}},
            '{16'sd5, 17'sd0, 17'sd0, 1'b1, '{SPD_POS_MAX, SPD_POS_MAX, 1'b1, 1'b1}},
            '{-16'sd5, 17'sd0, 17'sd0, 1'b1, '{SPD_NEG_MAX, SPD_NEG_MAX, 1'b1, 1'b1}},
            '{16'sd0, 17'sd0, 17'sd0, 1'b1, '{24'sd0, 24'sd0, 1'b0, 1'b0}},
            '{16'sd32767, 17'sd1, 17'sd0, 1'b1, '{SPD_POS_MAX, SPD_POS_MAX, 1'b0, 1'b1}},
            '{-16'sd32768, 17'sd1, 17'sd0, 1'b1, '{SPD_NEG_MAX, SPD_NEG_MAX, 1'b0, 1'b1}},
            '{16'sd1000, 17'sd0, 17'sd384, 1'b0, '0},
            '{16'sd1000, 17'sd65535, 17'sd65535, 1'b0, '0},
            '{-16'sd1000, -17'sd65536, -17'sd65536, 1'b0, '0},
            '{16'sd1, 17'sd2000, -17'sd300, 1'b0, '0},
            '{16'sd32767, 17'sd248, 17'sd384, 1'b0, '0},
            '{16'sd32767, -17'sd1600, 17'sd1200, 1'b0, '0},
            '{-16'sd1, -17'sd1, 17'sd1, 1'b0, '0}
        };
        set_w = '{8'd31, 8'd0, 8'd255, 8'd1, 8'd255, 8'd0, 8'd100};
        set_l = '{8'd48, 8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd77};

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table at reset settings
        gap_pct = 24;
        for (int i = 0; i < N_DIR; i++)
            send_beat(dir_rows[i].spd, dir_rows[i].cx, dir_rows[i].cy,
                      dir_rows[i].typed, dir_rows[i].want);

        // random beats under each setting
        for (int p = 0; p < N_SETS; p++)
        begin
            gap_pct = p < 2 ? 24 : (p < 4 ? 81 : 0);
            drain();
            write_reg(REG_WIDTH, p == N_SETS - 1 ? CFG_W'($urandom) : set_w[p]);
            write_reg(REG_LENGTH, p == N_SETS - 1 ? CFG_W'($urandom) : set_l[p]);
            write_reg(REG_SPARE, CFG_W'($urandom));
            for (int i = 0; i < RAND_PER_SET; i++)
                random_beat();
        end

        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
